// ===== rtl/mt19937_pkg.sv =====
`timescale 1ns / 1ps

package mt19937_pkg;

    // Algorithm dimensions
    localparam int unsigned MT_N  = 624;
    localparam int unsigned MT_M  = 397;
    localparam int unsigned MT_AW = $clog2(MT_N);

    // Recurrence, twist and tempering constants
    localparam logic [31:0] MT_INIT_MUL = 32'd1812433253;
    localparam logic [31:0] MT_MATRIX   = 32'h9908_b0df;
    localparam logic [31:0] MT_TEMPER_B = 32'd2636928640;
    localparam logic [31:0] MT_TEMPER_C = 32'd4022730752;

    // Item function codes
    localparam logic [1:0] FUNC_SEED = 2'd0;
    localparam logic [1:0] FUNC_RAW  = 2'd1;
    localparam logic [1:0] FUNC_SHR  = 2'd2;
    localparam logic [1:0] FUNC_MOD  = 2'd3;

    // Output tempering of one state word
    function automatic logic [31:0] mt_temper(input logic [31:0] w);
        logic [31:0] y;
        begin
            y = w ^ (w >> 11);
            y = y ^ ((y << 7) & MT_TEMPER_B);
            y = y ^ ((y << 15) & MT_TEMPER_C);
            y = y ^ (y >> 18);
            return y;
        end
    endfunction

endpackage

// ===== rtl/mt19937_mod_unit.sv =====
`timescale 1ns / 1ps

module mt19937_mod_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] remainder
);
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [31:0] dvd_reg;
    logic [31:0] dvd_next;
    logic [31:0] dsr_reg;
    logic [31:0] dsr_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic [32:0] shifted;

    // Bring down the next dividend bit
    assign shifted = {rem_reg, dvd_reg[31]};

    // One restoring shift-subtract step per cycle, MSB first
    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = 32'(shifted - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = shifted[31:0];
            end
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and partial remainder
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/mt19937_core.sv =====
`timescale 1ns / 1ps

module mt19937_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [31:0] seed_value,
    input  logic [31:0] bound,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [31:0] res_value
);
    import mt19937_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SEED  = 8'b0000_0010,
        ST_PRIME = 8'b0000_0100,
        ST_TWIST = 8'b0000_1000,
        ST_DRAIN = 8'b0001_0000,
        ST_READ  = 8'b0010_0000,
        ST_FETCH = 8'b0100_0000,
        ST_MOD   = 8'b1000_0000
    } core_state_t;

    localparam logic [MT_AW-1:0] LAST_IDX = MT_AW'(MT_N - 1);
    localparam logic [MT_AW-1:0] POS_END  = MT_AW'(MT_N);
    localparam logic [MT_AW-1:0] WRAP_IDX = MT_AW'(MT_N - MT_M);

    core_state_t      state_reg;
    core_state_t      state_next;
    logic [MT_AW-1:0] pos_reg;
    logic [MT_AW-1:0] pos_next;
    logic [MT_AW-1:0] idx_reg;
    logic [MT_AW-1:0] idx_next;
    logic [MT_AW-1:0] idx_d_reg;
    logic [MT_AW-1:0] idx_d_next;
    logic             proc_valid_reg;
    logic             proc_valid_next;
    logic             head_msb_reg;
    logic             head_msb_next;
    logic [31:0]      p_reg;
    logic [31:0]      p_next;
    logic [1:0]       func_reg;
    logic [1:0]       func_next;
    logic [31:0]      bound_reg;
    logic [31:0]      bound_next;

    // State word memory
    logic [31:0]      mem [0:MT_N-1];
    logic             wr_en;
    logic [MT_AW-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic             rd_a_en;
    logic [MT_AW-1:0] rd_a_addr;
    logic [31:0]      rd_a_data;
    logic             rd_b_en;
    logic [MT_AW-1:0] rd_b_addr;
    logic [31:0]      rd_b_data;

    logic [31:0]      seed_mix;
    logic [31:0]      seed_word;
    logic [31:0]      twist_y;
    logic [31:0]      twist_word;
    logic [31:0]      tempered;
    logic [31:0]      shaped;
    logic             div_start;
    logic             div_busy;
    logic [31:0]      div_rem;
    logic             accept;

    // Seeding recurrence
    assign seed_mix  = p_reg ^ (p_reg >> 30);
    assign seed_word = (MT_INIT_MUL * seed_mix) + 32'(idx_reg);

    // Twist of one word: upper bit of w[i], lower bits of w[i+1], mixed with w[i+M]
    assign twist_y    = {head_msb_reg, rd_a_data[30:0]};
    assign twist_word = rd_b_data ^ (twist_y >> 1) ^ (twist_y[0] ? MT_MATRIX : 32'd0);

    // Draw word shaping
    assign tempered = mt_temper(rd_a_data);
    assign shaped   = (func_reg == FUNC_SHR) ? (tempered >> 1) : tempered;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    mt19937_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (tempered),
        .divisor   (bound_reg),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    // Sequencer and memory port control
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        idx_d_next      = idx_d_reg;
        proc_valid_next = proc_valid_reg;
        head_msb_next   = head_msb_reg;
        p_next          = p_reg;
        func_next       = func_reg;
        bound_next      = bound_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = seed_word;
        rd_a_en         = 1'b0;
        rd_a_addr       = pos_reg;
        rd_b_en         = 1'b0;
        rd_b_addr       = idx_reg;
        res_valid       = 1'b0;
        res_value       = shaped;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    bound_next = bound;
                    if (func == FUNC_SEED)
                    begin
                        p_next     = seed_value;
                        idx_next   = '0;
                        state_next = ST_SEED;
                    end
                    else if (pos_reg >= POS_END)
                    begin
                        state_next = ST_PRIME;
                    end
                    else
                    begin
                        // Fetch the word at the current position right away
                        rd_a_en    = 1'b1;
                        rd_a_addr  = pos_reg;
                        pos_next   = pos_reg + MT_AW'(1);
                        state_next = ST_FETCH;
                    end
                end
            end

            ST_SEED:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = (idx_reg == '0) ? p_reg : seed_word;
                p_next  = wr_data;
                idx_next = idx_reg + MT_AW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    pos_next   = POS_END;
                    state_next = ST_IDLE;
                end
            end

            ST_PRIME:
            begin
                // Load w[0] so its upper bit is at hand for the first word
                rd_a_en         = 1'b1;
                rd_a_addr       = '0;
                idx_next        = '0;
                proc_valid_next = 1'b0;
                state_next      = ST_TWIST;
            end

            ST_TWIST:
            begin
                // Issue reads for word idx, retire word idx_d
                rd_a_en   = 1'b1;
                rd_a_addr = (idx_reg == LAST_IDX) ? '0 : idx_reg + MT_AW'(1);
                rd_b_en   = 1'b1;
                rd_b_addr = (idx_reg < WRAP_IDX) ? idx_reg + MT_AW'(MT_M)
                                                 : idx_reg - WRAP_IDX;
                wr_en     = proc_valid_reg;
                wr_addr   = idx_d_reg;
                wr_data   = twist_word;
                head_msb_next   = rd_a_data[31];
                idx_d_next      = idx_reg;
                proc_valid_next = 1'b1;
                idx_next        = idx_reg + MT_AW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                wr_en           = 1'b1;
                wr_addr         = idx_d_reg;
                wr_data         = twist_word;
                proc_valid_next = 1'b0;
                pos_next        = '0;
                state_next      = ST_READ;
            end

            ST_READ:
            begin
                rd_a_en    = 1'b1;
                rd_a_addr  = pos_reg;
                pos_next   = pos_reg + MT_AW'(1);
                state_next = ST_FETCH;
            end

            ST_FETCH:
            begin
                if ((func_reg == FUNC_MOD) && (bound_reg != '0))
                begin
                    div_start  = 1'b1;
                    state_next = ST_MOD;
                end
                else
                begin
                    res_valid = 1'b1;
                    res_value = shaped;
                    if (res_ready)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_MOD:
            begin
                res_value = div_rem;
                if (!div_busy)
                begin
                    res_valid = 1'b1;
                    if (res_ready)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= POS_END;
            idx_reg        <= '0;
            idx_d_reg      <= '0;
            proc_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            idx_reg        <= idx_next;
            idx_d_reg      <= idx_d_next;
            proc_valid_reg <= proc_valid_next;
        end
    end

    // Hold item payload and working words
    always_ff @(posedge clk)
    begin
        head_msb_reg <= head_msb_next;
        p_reg        <= p_next;
        func_reg     <= func_next;
        bound_reg    <= bound_next;
    end

    // Write one word, read two, registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_data <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_data <= mem[rd_b_addr];
        end
    end

    // Position never runs past the end of the state
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= POS_END)
        else $error("position beyond state length");

    // A twist write never lands on an entry read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_a_en && rd_b_en) |-> (wr_addr != rd_a_addr && wr_addr != rd_b_addr))
        else $error("twist write collides with a read");

    // A finished twist restarts the position at the first word
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> (pos_reg == '0 && state_reg == ST_READ))
        else $error("twist did not restart position");

    // No new item is taken while a result is offered
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !res_valid)
        else $error("result offered while idle");

endmodule

// ===== rtl/mt19937_generator.sv =====
`timescale 1ns / 1ps

// MT19937 32-bit random word generator. The 624-word state sits in one on-chip
// RAM with a registered read, one write port and two read ports. A seed beat
// fills the state one word per cycle; it returns no result. A draw beat reads
// the RAM, then tempers the word into the output register; the first draw after
// a seed and every 624th draw after that first runs the twist, one word per
// cycle. The modulo form also passes through the bit-serial remainder unit. One
// item is processed at a time; the output register lets the next item start
// while a result waits to be taken. Issue a seed beat before the first draw.
module mt19937_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [31:0] seed_value,
    input  logic [31:0] bound,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value
);
    logic        res_valid;
    logic        res_ready;
    logic [31:0] res_value;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] value_reg;
    logic [31:0] value_next;

    mt19937_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .seed_value (seed_value),
        .bound      (bound),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_value  (res_value)
    );

    // Output register: free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                value_next = res_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result beat
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule

// ===== dv/mt19937_generator_tb.sv =====
`timescale 1ns / 1ps

module mt19937_generator_tb;

    import mt19937_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned DRAIN_CYCLES = 700;
    localparam int unsigned ITEM_TARGET = 1350;
    localparam int unsigned IDLE_PERCENT = 26;
    localparam int unsigned QUIET_FIRST = 300;
    localparam int unsigned QUIET_LAST = 600;
    localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
    localparam logic [31:0] LOWER_MASK = 32'h7fff_ffff;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] seed_value;
        logic [31:0] bound;
    } mt_request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = FUNC_SEED;
    logic [31:0] seed_value = '0;
    logic [31:0] bound = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] value;

    // Generator state as predicted from the accepted beats
    logic [31:0] gen_words [MT_N];
    int unsigned gen_pos = MT_N;

    mt_request_t request_q [$];
    logic [31:0] expected_words [$];
    mt_request_t next_req;
    logic [31:0] want_word;
    int unsigned requests_sent = 0;
    int unsigned total_requests = 0;
    int unsigned words_expected = 0;
    int unsigned words_checked = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    mt19937_generator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .seed_value (seed_value),
        .bound      (bound),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Fill the state from a seed word with the init recurrence
    function automatic void seed_state(input logic [31:0] s);
        logic [31:0] prev;
        gen_words[0] = s;
        for (int unsigned i = 1; i < MT_N; i++)
        begin
            prev = gen_words[i - 1];
            gen_words[i] = MT_INIT_MUL * (prev ^ (prev >> 30)) + 32'(i);
        end
        gen_pos = MT_N;
    endfunction

    // Regenerate all 624 words in place
    function automatic void twist_state();
        logic [31:0] y;
        logic [31:0] m;
        for (int unsigned i = 0; i < MT_N; i++)
        begin
            y = (gen_words[i] & UPPER_MASK) | (gen_words[(i + 1) % MT_N] & LOWER_MASK);
            m = gen_words[(i + MT_M) % MT_N] ^ (y >> 1);
            if (y[0])
                m = m ^ MT_MATRIX;
            gen_words[i] = m;
        end
        gen_pos = 0;
    endfunction

    function automatic logic [31:0] tempered(input logic [31:0] w);
        logic [31:0] t;
        t = w ^ (w >> 11);
        t = t ^ ((t << 7) & MT_TEMPER_B);
        t = t ^ ((t << 15) & MT_TEMPER_C);
        return t ^ (t >> 18);
    endfunction

    // Advance the predicted generator by one accepted beat
    function automatic void apply_request(input mt_request_t req);
        logic [31:0] w;
        if (req.func == FUNC_SEED)
        begin
            seed_state(req.seed_value);
            return;
        end
        if (gen_pos >= MT_N)
            twist_state();
        w = tempered(gen_words[gen_pos % MT_N]);
        gen_pos = (gen_pos + 1) & 32'h3ff;
        if (req.func == FUNC_SHR)
            w = w >> 1;
        else if (req.func == FUNC_MOD && req.bound != 0)
            w = w % req.bound;
        expected_words = {expected_words, w};
        words_expected++;
    endfunction

    function automatic void queue_request(input logic [1:0] f, input logic [31:0] s,
                                          input logic [31:0] b);
        mt_request_t req;
        req.func = f;
        req.seed_value = s;
        req.bound = b;
        request_q = {request_q, req};
    endfunction

    // Pick a modulus: zero, tiny, a power of two or any word
    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 32'($urandom_range(1, 16));
            2: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_draw();
        queue_request(2'($urandom_range(FUNC_RAW, FUNC_MOD)), $urandom, pick_bound());
    endfunction

    // Drive request beats; predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= FUNC_SEED;
            seed_value <= '0;
            bound <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_request('{func, seed_value, bound});
                requests_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (request_q.size() != 0 &&
                    ((requests_sent >= QUIET_FIRST && requests_sent < QUIET_LAST) ||
                     $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    next_req = request_q.pop_front();
                    in_valid <= 1'b1;
                    func <= next_req.func;
                    seed_value <= next_req.seed_value;
                    bound <= next_req.bound;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("value: no result expected, actual %08h", value);
                    mismatches++;
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (value !== want_word)
                    begin
                        $error("value: expected %08h, actual %08h", want_word, value);
                        mismatches++;
                    end
                end
                words_checked++;
            end
            out_ready <= (words_checked >= QUIET_FIRST && words_checked < QUIET_LAST) ||
                         ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int unsigned run_len;
        bit first_run;

        // Directed: bound extremes, every form, reseeding with and without draws
        queue_request(FUNC_SEED, 32'h0000_0000, 32'hffff_ffff);
        queue_request(FUNC_RAW, 32'hffff_ffff, 32'hffff_ffff);
        queue_request(FUNC_SHR, 32'hffff_ffff, 32'h0000_0000);
        queue_request(FUNC_MOD, 32'h0000_0000, 32'h0000_0000);
        queue_request(FUNC_MOD, 32'h0000_0000, 32'h0000_0001);
        queue_request(FUNC_MOD, 32'h0000_0000, 32'hffff_ffff);
        queue_request(FUNC_MOD, 32'h0000_0000, 32'h8000_0000);
        queue_request(FUNC_MOD, 32'h0000_0000, 32'h0000_0002);
        queue_request(FUNC_SEED, 32'hffff_ffff, 32'h0000_0000);
        queue_request(FUNC_RAW, 32'h0000_0000, 32'h0000_0000);
        queue_request(FUNC_MOD, 32'h0000_0000, 32'h0000_0007);
        queue_request(FUNC_SHR, 32'h0000_0000, 32'h0000_0000);
        queue_request(FUNC_SEED, 32'd5489, 32'h0000_0000);
        queue_request(FUNC_RAW, 32'h0000_0000, 32'h0000_0000);
        queue_request(FUNC_RAW, 32'h0000_0000, 32'h0000_0000);
        queue_request(FUNC_SHR, 32'h0000_0000, 32'h0000_0000);
        queue_request(FUNC_SEED, 32'h8000_0000, 32'h0000_0000);
        queue_request(FUNC_SEED, 32'h0000_0001, 32'h0000_0000);
        queue_request(FUNC_MOD, 32'h5555_5555, 32'haaaa_aaaa);
        queue_request(FUNC_RAW, 32'haaaa_aaaa, 32'h5555_5555);

        // Random: seeded runs of draws; the first crosses a second twist
        first_run = 1'b1;
        while (request_q.size() < ITEM_TARGET)
        begin
            queue_request(FUNC_SEED, pick_seed(), $urandom);
            if (first_run)
                run_len = 650;
            else if ($urandom_range(0, 19) == 0)
                run_len = $urandom_range(625, 700);
            else
                run_len = $urandom_range(0, 40);
            first_run = 1'b0;
            // Keep the total near the target
            if (run_len > ITEM_TARGET - request_q.size())
                run_len = ITEM_TARGET - request_q.size();
            repeat (run_len)
                queue_draw();
        end
        total_requests = request_q.size();

        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Drain: all beats taken, all results back, then let a trailing seed finish
        wait (requests_sent == total_requests);
        wait (words_checked >= words_expected);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mt19937_pkg.sv
rtl/mt19937_mod_unit.sv
rtl/mt19937_core.sv
rtl/mt19937_generator.sv
dv/mt19937_generator_tb.sv
